/* rtl/core/iad_pkg.sv */
// ----------------------------------------------------------------------------
// iad_pkg
// Shared types, constants and helpers for the integer-to-ASCII converter.
// ----------------------------------------------------------------------------
package iad_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int NIB_W      = 4;
    localparam int DEC_DIGITS = 20;
    localparam int DIGS_W     = DEC_DIGITS * NIB_W;
    localparam int CNT_W      = 5;
    localparam int ITER_W     = 6;
    localparam int PRE_W      = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h61;

    localparam logic [CNT_W-1:0]  HEX32_DIGITS = 5'd8;
    localparam logic [CNT_W-1:0]  HEX64_DIGITS = 5'd16;
    localparam logic [ITER_W-1:0] DEC32_ITERS  = 6'd31;
    localparam logic [ITER_W-1:0] DEC64_ITERS  = 6'd63;
    localparam logic [PRE_W-1:0]  PRE_ZERO     = 2'd2;
    localparam logic [PRE_W-1:0]  PRE_X        = 2'd1;
    localparam logic [PRE_W-1:0]  PRE_DONE     = 2'd0;

    localparam int FUNC_HEX_BIT  = 0;
    localparam int FUNC_WIDE_BIT = 1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               hex;
        logic               wide;
    } job_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'b0, d};
        end else begin
            c = CHAR_A + {4'b0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

/* rtl/core/iad_front.sv */
// ----------------------------------------------------------------------------
// iad_front
// Accepts input transfers, holds the hex_only register and classifies each
// request into a conversion job for the queue.
// ----------------------------------------------------------------------------
module iad_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [iad_pkg::VALUE_W-1:0]    s_tdata,
    input  logic [iad_pkg::FUNC_W-1:0]     s_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output iad_pkg::job_t                  push_job
);

    logic hex_only_reg;
    logic hex_only_next;
    logic wide;

    assign cfg_ready = 1'b1;

    always_comb begin
        hex_only_next = hex_only_reg;
        if (cfg_valid) begin
            hex_only_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_only_reg <= 1'b0;
        end else begin
            hex_only_reg <= hex_only_next;
        end
    end

    assign wide       = s_tuser[iad_pkg::FUNC_WIDE_BIT];
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_job.wide  = wide;
        push_job.hex   = s_tuser[iad_pkg::FUNC_HEX_BIT] | (!wide & hex_only_reg);
        push_job.value = wide ? s_tdata : {32'b0, s_tdata[31:0]};
    end

endmodule

/* rtl/core/iad_queue.sv */
// ----------------------------------------------------------------------------
// iad_queue
// Short job queue that decouples the front end from the conversion engine.
// ----------------------------------------------------------------------------
module iad_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  iad_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output iad_pkg::job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    iad_pkg::job_t    entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/iad_back.sv */
// ----------------------------------------------------------------------------
// iad_back
// Conversion engine: shift-and-add-3 binary to BCD for decimal jobs, nibble
// shifting for hex jobs, and a registered character output stage.
// ----------------------------------------------------------------------------
module iad_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  iad_pkg::job_t               job,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [iad_pkg::CHAR_W-1:0]  m_tdata,
    output logic                        m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    localparam int DW = iad_pkg::DIGS_W;
    localparam int NW = iad_pkg::NIB_W;
    localparam int VW = iad_pkg::VALUE_W;

    state_t                         state_reg, state_next;
    logic [DW-1:0]                  digs_reg, digs_next;
    logic [VW-1:0]                  bin_reg, bin_next;
    logic [iad_pkg::ITER_W-1:0]     iter_reg, iter_next;
    logic [iad_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [iad_pkg::PRE_W-1:0]      pre_reg, pre_next;
    logic                           m_valid_reg, m_valid_next;
    logic [iad_pkg::CHAR_W-1:0]     m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    logic [DW-1:0]                  adj;
    logic [NW-1:0]                  top_nib;
    logic [iad_pkg::CHAR_W-1:0]     cur_char;
    logic                           cur_last;
    logic                           out_free;

    assign top_nib  = digs_reg[DW-1 -: NW];
    assign out_free = !m_valid_reg || m_tready;
    assign cur_last = (pre_reg == iad_pkg::PRE_DONE) && (cnt_reg == 5'd1);

    always_comb begin
        for (int i = 0; i < iad_pkg::DEC_DIGITS; i++) begin
            adj[i*NW +: NW] = (digs_reg[i*NW +: NW] >= 4'd5) ?
                              digs_reg[i*NW +: NW] + 4'd3 : digs_reg[i*NW +: NW];
        end
    end

    always_comb begin
        case (pre_reg)
            iad_pkg::PRE_ZERO: cur_char = iad_pkg::CHAR_ZERO;
            iad_pkg::PRE_X:    cur_char = iad_pkg::CHAR_X;
            default:           cur_char = iad_pkg::digit_char(top_nib);
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        digs_next    = digs_reg;
        bin_next     = bin_reg;
        iter_next    = iter_reg;
        cnt_next     = cnt_reg;
        pre_next     = pre_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        job_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    if (job.hex) begin
                        digs_next  = job.wide ? {job.value, 16'b0}
                                              : {job.value[31:0], 48'b0};
                        cnt_next   = job.wide ? iad_pkg::HEX64_DIGITS
                                              : iad_pkg::HEX32_DIGITS;
                        pre_next   = iad_pkg::PRE_ZERO;
                        state_next = ST_EMIT;
                    end else begin
                        digs_next  = '0;
                        bin_next   = job.wide ? job.value : {job.value[31:0], 32'b0};
                        iter_next  = job.wide ? iad_pkg::DEC64_ITERS
                                              : iad_pkg::DEC32_ITERS;
                        pre_next   = iad_pkg::PRE_DONE;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                {digs_next, bin_next} = {adj, bin_reg} << 1;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    cnt_next   = iad_pkg::CNT_W'(iad_pkg::DEC_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_nib == '0 && cnt_reg > 5'd1) begin
                    digs_next = digs_reg << NW;
                    cnt_next  = cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = cur_char;
                    m_last_next  = cur_last;
                    if (pre_reg != iad_pkg::PRE_DONE) begin
                        pre_next = pre_reg - 1'b1;
                    end else begin
                        digs_next = digs_reg << NW;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                    if (cur_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        digs_reg   <= digs_next;
        bin_reg    <= bin_next;
        iter_reg   <= iter_next;
        cnt_reg    <= cnt_next;
        pre_reg    <= pre_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/core/integer_to_ascii_dec_hex_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_dec_hex_unit
// Converts an unsigned value to ASCII decimal or 0x-prefixed hex text, one
// character per output transfer, most significant character first.
//
// Channel   Direction  Payload
// s_        in         tdata = value[63:0], tuser = func[1:0]
// m_        out        tdata = ascii_char[7:0], tlast = last_char
// cfg_      in         data = hex_only
//
// Hex jobs emit 10 or 18 characters at one per cycle while not stalled.
// Decimal jobs run the BCD shift loop over 32 or 64 bits, drop leading zeros
// at one digit per cycle, then emit the digits. Reset clears the queue, the
// output register and hex_only. Output stalls hold the engine; the queue
// keeps taking input transfers until it is full.
// ----------------------------------------------------------------------------
module integer_to_ascii_dec_hex_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [iad_pkg::VALUE_W-1:0]    s_tdata,   // [63:0] value
    input  logic [iad_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iad_pkg::CHAR_W-1:0]     m_tdata,   // [7:0] ascii_char
    output logic                           m_tlast
);

    logic          push_valid;
    logic          push_ready;
    iad_pkg::job_t push_job;
    logic          pop_valid;
    logic          pop_ready;
    iad_pkg::job_t pop_job;

    iad_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    iad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    iad_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
